### src/sstr_pkg.sv
// Shared types, constants and segment table for the seven-segment text router.
`timescale 1ns / 1ps
`default_nettype none
package sstr_pkg;

   localparam int unsigned MAX_DIGITS   = 6;
   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SEG_LUT_SIZE = 123;

   localparam logic [7:0] DP_BIT     = 8'h80;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] IMG_BLANK  = 8'h00;
   localparam logic [2:0] SLOTS_PER_CHIP = 3'd3;
   localparam logic [2:0] LAST_CLEAR_BEAT = 3'd6;

   // Decoded request handed from the front end to the writer.
   typedef struct packed {
      logic       show;
      logic       chip;
      logic [2:0] addr;
      logic [7:0] img;
      logic       dbl;
      logic [2:0] count;
      logic       eos;
   } job_type;

   localparam logic [7:0] SEG_LUT [SEG_LUT_SIZE] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00,
      8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
      8'h7F, 8'h7B, 8'h00, 8'h00, 8'h0C, 8'h09, 8'h60, 8'h65,
      8'h00, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E,
      8'h37, 8'h10, 8'h3C, 8'h37, 8'h0E, 8'h54, 8'h76, 8'h7E,
      8'h67, 8'h73, 8'h05, 8'h5B, 8'h46, 8'h3E, 8'h1C, 8'h2A,
      8'h37, 8'h2F, 8'h6D, 8'h00, 8'h00, 8'h00, 8'h63, 8'h08,
      8'h00, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5E,
      8'h17, 8'h10, 8'h3C, 8'h37, 8'h0C, 8'h54, 8'h15, 8'h1D,
      8'h67, 8'h73, 8'h05, 8'h5B, 8'h0F, 8'h1C, 8'h1C, 8'h2A,
      8'h37, 8'h2F, 8'h6D
   };

   function automatic logic [7:0] image_of(input logic [7:0] code);
      logic [7:0] img;
      begin
         img = IMG_BLANK;
         if (code < 8'(SEG_LUT_SIZE)) begin
            img = SEG_LUT[code[6:0]];
         end
         return img;
      end
   endfunction

endpackage
`default_nettype wire

### src/seven_segment_text_router.sv
// Top level of the seven-segment text router.
//
//   channel  direction  ports
//   req      in         req_valid/req_ready, char_code, end_of_string, light_level
//   rsp      out        rsp_valid/rsp_ready, chip, address, image, flags, count
//   csr      in         csr_write_enable, csr_write_data (intensity mode)
//
// A request is taken and queued; the writer sends 1, 2 or 7 responses for it,
// one per cycle unless rsp_ready stalls it. The two-entry queue lets requests
// come in while writes go out.
// Reset is synchronous and returns position, dot and count state to start.
// Backpressure on rsp fills the queue and then drops req_ready.
`timescale 1ns / 1ps
`default_nettype none
module seven_segment_text_router (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_char_code,
   input  wire         req_end_of_string,
   input  wire  [15:0] req_light_level,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_chip_select,
   output logic [2:0]  rsp_digit_address,
   output logic [7:0]  rsp_segment_image,
   output logic        rsp_write_enable,
   output logic        rsp_run_last,
   output logic        rsp_string_done,
   output logic [2:0]  rsp_shown_count,
   input  wire         csr_write_enable,
   input  wire  [7:0]  csr_write_data
);
   import sstr_pkg::*;

   job_type push_job;
   job_type head_job;
   logic    q_push, q_pop, q_empty, q_full;

   sstr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .req_light_level   (req_light_level),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_job             (push_job)
   );

   sstr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (push_job),
      .pop   (q_pop),
      .rdata (head_job),
      .empty (q_empty),
      .full  (q_full)
   );

   sstr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_job             (head_job),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chip_select   (rsp_chip_select),
      .rsp_digit_address (rsp_digit_address),
      .rsp_segment_image (rsp_segment_image),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_run_last      (rsp_run_last),
      .rsp_string_done   (rsp_string_done),
      .rsp_shown_count   (rsp_shown_count)
   );

endmodule
`default_nettype wire

### src/sstr_front.sv
// Front end: takes characters, tracks position, dot and count, builds jobs.
`timescale 1ns / 1ps
`default_nettype none
module sstr_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [7:0]            req_char_code,
   input  wire                   req_end_of_string,
   input  wire  [15:0]           req_light_level,
   input  wire                   csr_write_enable,
   input  wire  [7:0]            csr_write_data,
   input  wire                   q_full,
   output logic                  q_push,
   output sstr_pkg::job_type     q_job
);
   import sstr_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic       dot_ff, dot_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] mode_ff, mode_in;
   logic [2:0] p;
   logic [1:0] slot;
   logic       in_range;
   logic       show;
   logic [7:0] img;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;
   assign mode_in   = csr_write_enable ? csr_write_data : mode_ff;
   assign in_range  = (pos_ff >= 3'd1) && (pos_ff <= 3'(MAX_DIGITS));
   assign p         = pos_ff - 3'd1;
   assign slot      = (p >= SLOTS_PER_CHIP) ? 2'(p - SLOTS_PER_CHIP) : p[1:0];

   always_comb begin
      show   = 1'b0;
      img    = IMG_BLANK;
      dot_in = dot_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      if (in_range) begin
         if (dot_ff) begin
            img    = image_of(req_char_code) | DP_BIT;
            dot_in = 1'b0;
            show   = 1'b1;
         end else if (req_char_code == CHAR_DOT) begin
            if (req_end_of_string) begin
               img  = image_of(req_char_code) | DP_BIT;
               show = 1'b1;
            end else begin
               dot_in = 1'b1;
            end
         end else begin
            if (req_char_code != CHAR_SPACE) begin
               cnt_in = cnt_ff + 3'd1;
            end
            img  = image_of(req_char_code);
            show = 1'b1;
         end
      end
      if (show) begin
         pos_in = pos_ff + 3'd1;
      end

      q_job.show  = show;
      q_job.chip  = (p >= SLOTS_PER_CHIP);
      q_job.addr  = 3'd1 + {slot, 1'b0};
      q_job.img   = img;
      q_job.dbl   = (mode_ff == 8'd0) ? (|req_light_level[15:8]) : (mode_ff > 8'd1);
      q_job.count = cnt_in;
      q_job.eos   = req_end_of_string;

      if (req_end_of_string) begin
         pos_in = 3'd1;
         dot_in = 1'b0;
         cnt_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 3'd1;
         dot_ff  <= 1'b0;
         cnt_ff  <= 3'd0;
         mode_ff <= 8'd0;
      end else begin
         mode_ff <= mode_in;
         if (q_push) begin
            pos_ff <= pos_in;
            dot_ff <= dot_in;
            cnt_ff <= cnt_in;
         end
      end
   end

endmodule
`default_nettype wire

### src/sstr_queue.sv
// Short job queue between the front end and the register writer.
`timescale 1ns / 1ps
`default_nettype none
module sstr_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  sstr_pkg::job_type     wdata,
   input  wire                   pop,
   output sstr_pkg::job_type     rdata,
   output logic                  empty,
   output logic                  full
);
   import sstr_pkg::*;

   job_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign rdata = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### src/sstr_back.sv
// Register writer: expands each job into driver writes through an output register.
`timescale 1ns / 1ps
`default_nettype none
module sstr_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_empty,
   input  sstr_pkg::job_type     q_job,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic                  rsp_chip_select,
   output logic [2:0]            rsp_digit_address,
   output logic [7:0]            rsp_segment_image,
   output logic                  rsp_write_enable,
   output logic                  rsp_run_last,
   output logic                  rsp_string_done,
   output logic [2:0]            rsp_shown_count
);
   import sstr_pkg::*;

   logic [2:0] beat_ff, beat_in;
   logic       valid_ff, valid_in;
   logic       load, last;
   logic       chip_in, we_in;
   logic [2:0] addr_in;
   logic [7:0] img_in;
   logic       chip_ff, we_ff, last_ff, done_ff;
   logic [2:0] addr_ff, cnt_ff;
   logic [7:0] img_ff;

   assign load = !q_empty && (!valid_ff || rsp_ready);

   always_comb begin
      chip_in = 1'b0;
      addr_in = 3'd0;
      img_in  = IMG_BLANK;
      we_in   = 1'b0;
      last    = 1'b1;
      if (q_job.show) begin
         we_in = 1'b1;
         if (beat_ff == 3'd0) begin
            chip_in = q_job.chip;
            addr_in = q_job.addr;
            img_in  = q_job.img;
            last    = 1'b0;
         end else if (q_job.dbl) begin
            chip_in = q_job.chip;
            addr_in = q_job.addr + 3'd1;
            img_in  = q_job.img;
         end else begin
            last = (beat_ff == LAST_CLEAR_BEAT);
            // clear the second-hit registers of both chips
            case (beat_ff)
               3'd1: begin chip_in = 1'b0; addr_in = 3'd2; end
               3'd2: begin chip_in = 1'b0; addr_in = 3'd4; end
               3'd3: begin chip_in = 1'b0; addr_in = 3'd6; end
               3'd4: begin chip_in = 1'b1; addr_in = 3'd2; end
               3'd5: begin chip_in = 1'b1; addr_in = 3'd4; end
               default: begin chip_in = 1'b1; addr_in = 3'd6; end
            endcase
         end
      end
   end

   assign q_pop    = load && last;
   assign beat_in  = last ? 3'd0 : beat_ff + 3'd1;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            beat_ff <= beat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chip_ff <= chip_in;
         addr_ff <= addr_in;
         img_ff  <= img_in;
         we_ff   <= we_in;
         last_ff <= last;
         done_ff <= last && q_job.eos;
         cnt_ff  <= q_job.count;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_chip_select   = chip_ff;
   assign rsp_digit_address = addr_ff;
   assign rsp_segment_image = img_ff;
   assign rsp_write_enable  = we_ff;
   assign rsp_run_last      = last_ff;
   assign rsp_string_done   = done_ff;
   assign rsp_shown_count   = cnt_ff;

endmodule
`default_nettype wire
